// ===== rtl/core/ess_pkg.sv =====
// Shared types, codes and defaults of the envelope silence segmenter.
`default_nettype none
package ess_pkg;

    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_MAX_BLOCKS  = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 2;

    localparam logic [15:0] RST_THRESHOLD = 16'd328;
    localparam logic [24:0] RST_MIN_SIL   = 25'd22050;
    localparam logic [24:0] RST_MIN_BLK   = 25'd4410;
    localparam logic [15:0] RST_COEFF     = 16'd65238;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_MIN_SIL   = 2'd1,
        CFG_MIN_BLK   = 2'd2,
        CFG_COEFF     = 2'd3
    } t_cfg_idx;

    localparam logic KIND_BLOCK = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef struct packed {
        logic [15:0] threshold;
        logic [24:0] min_sil;
        logic [24:0] min_blk;
        logic [15:0] coeff;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FWD_RD,
        ST_FWD_UPD,
        ST_BWD_RD,
        ST_BWD_UPD,
        ST_SCAN_RD,
        ST_SCAN_UPD,
        ST_END
    } t_seg_state;

endpackage
`default_nettype wire

// ===== rtl/core/envelope_silence_segmenter_top.sv =====
// Top level of the envelope silence segmenter: configuration and both halves.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_stall    i_sample, i_last
//   result    out        o_valid / i_stall    o_kind, o_block_index, o_start_sample,
//                                             o_end_sample, o_max_amplitude,
//                                             o_overflow, o_final_record
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Samples are loaded at one beat per cycle, while the back end is in its load
// state, through a two-entry queue into the sample store. After the last beat
// the back end runs the forward peak-hold pass and then the backward pass (read,
// then multiply-and-compare on a single-port store with a registered decay
// product), then segmentation and finally the end record; result stalls hold both.
// Reset is synchronous and active low; the stores are not cleared, since only
// entries written in the current run are read. A stall on the result channel
// freezes segmentation; input beats keep filling the queue until it is full.
`default_nettype none
module envelope_silence_segmenter_top import ess_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_kind,
    output logic [5:0]                  o_block_index,
    output logic [16:0]                 o_start_sample,
    output logic [16:0]                 o_end_sample,
    output logic [15:0]                 o_max_amplitude,
    output logic                        o_overflow,
    output logic                        o_final_record
);

    t_cfg                   r_cfg;
    logic                   w_q_valid;
    logic [SAMPLE_BITS-1:0] w_q_mag;
    logic                   w_q_last;
    logic                   w_q_pop;

    // Configuration registers; write them only while the block is idle. The block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.min_sil   <= RST_MIN_SIL;
            r_cfg.min_blk   <= RST_MIN_BLK;
            r_cfg.coeff     <= RST_COEFF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[15:0];
                CFG_MIN_SIL:   r_cfg.min_sil   <= i_cfg_data;
                CFG_MIN_BLK:   r_cfg.min_blk   <= i_cfg_data;
                CFG_COEFF:     r_cfg.coeff     <= i_cfg_data[15:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // The front end classifies beats and forms magnitudes; it only stalls when
    // its queue is full, which happens while the back end runs its passes.
    ess_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample  (i_sample),
        .i_last    (i_last),
        .o_q_valid (w_q_valid),
        .o_q_mag   (w_q_mag),
        .o_q_last  (w_q_last),
        .i_q_pop   (w_q_pop)
    );

    // The back end owns both stores and the result register.
    ess_back #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .MAX_BLOCKS (MAX_BLOCKS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (w_q_valid),
        .i_q_mag         (w_q_mag),
        .i_q_last        (w_q_last),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_block_index   (o_block_index),
        .o_start_sample  (o_start_sample),
        .o_end_sample    (o_end_sample),
        .o_max_amplitude (o_max_amplitude),
        .o_overflow      (o_overflow),
        .o_final_record  (o_final_record)
    );

endmodule
`default_nettype wire

// ===== rtl/core/ess_front.sv =====
// Front end: takes input beats, forms the sample magnitude and queues them.
`default_nettype none
module ess_front import ess_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_last,
    output logic                        o_q_valid,
    output logic [SAMPLE_BITS-1:0]      o_q_mag,
    output logic                        o_q_last,
    input  wire logic                   i_q_pop
);

    logic [SAMPLE_BITS-1:0] r_mag [2];
    logic                   r_last [2];
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_cnt;
    logic [1:0]             n_cnt;
    logic                   w_push;
    logic                   w_pop;
    logic [SAMPLE_BITS-1:0] w_mag;

    // Two's complement magnitude; the most negative code maps to 2^(bits-1).
    assign w_mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_mag   = r_mag[r_rd_ptr];
    assign o_q_last  = r_last[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mag[r_wr_ptr]  <= w_mag;
            r_last[r_wr_ptr] <= i_last;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ess_back.sv =====
// Back end: sample and envelope stores, peak-hold passes, segmentation, results.
`default_nettype none
module ess_back import ess_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_q_valid,
    input  wire logic [SAMPLE_BITS-1:0] i_q_mag,
    input  wire logic                   i_q_last,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_kind,
    output logic [5:0]                  o_block_index,
    output logic [16:0]                 o_start_sample,
    output logic [16:0]                 o_end_sample,
    output logic [15:0]                 o_max_amplitude,
    output logic                        o_overflow,
    output logic                        o_final_record
);

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int KW    = $clog2(MAX_BLOCKS + 1);
    localparam int CW    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int LW    = (CNT_W > 25) ? CNT_W : 25;
    localparam int PW    = SAMPLE_BITS + 16;

    logic [SAMPLE_BITS-1:0] mem_s [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] mem_e [MAX_SAMPLES];

    t_seg_state             r_state;
    t_seg_state             n_state;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_n;
    logic [CNT_W-1:0]       r_idx;
    logic                   r_ovf;
    logic [KW-1:0]          r_k;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [PW-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0] r_s_rd;
    logic [SAMPLE_BITS-1:0] r_e_rd;
    logic                   r_in_sil;
    logic [CNT_W-1:0]       r_sil;
    logic [CNT_W-1:0]       r_blk;
    logic [SAMPLE_BITS-1:0] r_run_max;
    logic [SAMPLE_BITS-1:0] r_snap;
    logic                   r_out_valid;

    logic                   w_s_we;
    logic                   w_e_we;
    logic [SAMPLE_BITS-1:0] w_d;
    logic [SAMPLE_BITS-1:0] w_peak;
    logic                   w_room;
    logic                   w_silent;
    logic                   w_trans;
    logic                   w_at_end;
    logic [CNT_W-1:0]       w_c_start;
    logic [CNT_W-1:0]       w_c_end;
    logic [SAMPLE_BITS-1:0] w_c_amp;
    logic                   w_qual;
    logic                   w_k_full;
    logic                   w_blk_emit;
    logic                   w_scan_go;
    logic                   w_end_emit;
    logic [SAMPLE_BITS-1:0] w_run_next;

    assign w_d    = r_prod[PW-1:16];
    assign w_peak = (r_s_rd > w_d) ? r_s_rd : w_d;
    assign w_room = !r_out_valid || !i_stall;

    assign w_at_end = (r_idx == r_n);
    assign w_silent = !w_at_end && (CW'(r_e_rd) < CW'(i_cfg.threshold));
    assign w_trans  = r_in_sil && !w_silent &&
                      (LW'(r_idx - r_sil) >= LW'(i_cfg.min_sil));

    // Region candidate: closed by a long silence, or the tail at the end.
    assign w_c_start = r_blk;
    assign w_c_end   = w_trans ? r_sil : r_n;
    assign w_c_amp   = w_trans ? r_snap : r_run_max;
    assign w_qual    = (w_trans || w_at_end) && (w_c_end > w_c_start) &&
                       (CW'(w_c_amp) >= CW'(i_cfg.threshold)) &&
                       (LW'(w_c_end - w_c_start) >= LW'(i_cfg.min_blk));
    assign w_k_full  = (r_k >= KW'(MAX_BLOCKS));
    assign w_run_next = (r_s_rd > r_run_max) ? r_s_rd : r_run_max;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_q_valid && i_q_last) begin
                    n_state = ST_FWD_RD;
                end
            end
            ST_FWD_RD:  n_state = ST_FWD_UPD;
            ST_FWD_UPD: n_state = (r_idx == r_n - 1'b1) ? ST_BWD_RD : ST_FWD_RD;
            ST_BWD_RD:  n_state = ST_BWD_UPD;
            ST_BWD_UPD: n_state = (r_idx == '0) ? ST_SCAN_RD : ST_BWD_RD;
            ST_SCAN_RD: n_state = ST_SCAN_UPD;
            ST_SCAN_UPD: begin
                if (w_scan_go) begin
                    n_state = w_at_end ? ST_END : ST_SCAN_RD;
                end
            end
            ST_END: begin
                if (w_room) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_q_pop    = 1'b0;
        w_s_we     = 1'b0;
        w_e_we     = 1'b0;
        w_blk_emit = 1'b0;
        w_scan_go  = 1'b0;
        w_end_emit = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_q_pop = i_q_valid;
                w_s_we  = i_q_valid && (r_count < CNT_W'(MAX_SAMPLES));
            end
            ST_FWD_UPD: w_e_we = 1'b1;
            ST_BWD_UPD: w_e_we = (w_peak > r_e_rd);
            ST_SCAN_UPD: begin
                w_blk_emit = w_qual && !w_k_full && w_room;
                w_scan_go  = !(w_qual && !w_k_full) || w_room;
            end
            ST_END: w_end_emit = w_room;
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    // Stores: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            mem_s[r_count[AW-1:0]] <= i_q_mag;
        end
        r_s_rd <= mem_s[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_e_we) begin
            mem_e[r_idx[AW-1:0]] <= w_peak;
        end
        r_e_rd <= mem_e[r_idx[AW-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_k         <= '0;
            r_in_sil    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_s_we) begin
                r_count <= r_count + 1'b1;
            end else if (o_q_pop) begin
                r_ovf <= 1'b1;
            end
            if (r_state == ST_BWD_UPD) begin
                r_k      <= '0;
                r_in_sil <= 1'b0;
            end
            if (r_state == ST_SCAN_UPD && w_scan_go) begin
                if (w_qual && w_k_full) begin
                    r_ovf <= 1'b1;
                end
                if (w_blk_emit) begin
                    r_k <= r_k + 1'b1;
                end
                if (!r_in_sil && w_silent) begin
                    r_in_sil <= 1'b1;
                end else if (r_in_sil && !w_silent) begin
                    r_in_sil <= 1'b0;
                end
            end
            if (w_end_emit) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (w_blk_emit || w_end_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                r_idx  <= '0;
                r_peak <= '0;
                if (w_s_we) begin
                    r_n <= r_count + 1'b1;
                end else begin
                    r_n <= r_count;
                end
            end
            ST_FWD_RD, ST_BWD_RD: begin
                r_prod <= PW'(r_peak) * PW'(i_cfg.coeff);
            end
            ST_FWD_UPD: begin
                if (r_idx == r_n - 1'b1) begin
                    r_peak <= '0;
                end else begin
                    r_peak <= w_peak;
                    r_idx  <= r_idx + 1'b1;
                end
            end
            ST_BWD_UPD: begin
                r_peak <= w_peak;
                if (r_idx == '0) begin
                    r_blk     <= '0;
                    r_run_max <= '0;
                end else begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            ST_SCAN_RD: begin
                r_prod <= r_prod;
            end
            ST_SCAN_UPD: begin
                if (w_scan_go) begin
                    r_idx <= r_idx + 1'b1;
                    if (!r_in_sil && w_silent) begin
                        r_sil     <= r_idx;
                        r_snap    <= r_run_max;
                        r_run_max <= w_run_next;
                    end else if (w_trans) begin
                        r_blk     <= r_idx;
                        r_run_max <= w_at_end ? '0 : r_s_rd;
                    end else if (!w_at_end) begin
                        r_run_max <= w_run_next;
                    end
                end
            end
            ST_END: begin
                r_idx <= '0;
            end
            default: begin
                r_idx <= '0;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_blk_emit) begin
            o_kind          <= KIND_BLOCK;
            o_block_index   <= 6'(r_k) + 6'd1;
            o_start_sample  <= 17'(w_c_start);
            o_end_sample    <= 17'(w_c_end);
            o_max_amplitude <= 16'(w_c_amp);
            o_overflow      <= 1'b0;
            o_final_record  <= 1'b0;
        end else if (w_end_emit) begin
            o_kind          <= KIND_END;
            o_block_index   <= 6'(r_k);
            o_start_sample  <= '0;
            o_end_sample    <= '0;
            o_max_amplitude <= '0;
            o_overflow      <= r_ovf;
            o_final_record  <= 1'b1;
        end
    end

    assign o_valid = r_out_valid;

    a_k_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= KW'(MAX_BLOCKS))
        else $error("block count beyond limit");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_emit |=> (r_count == '0) && !r_ovf && (r_state == ST_LOAD))
        else $error("run state not cleared after end record");

    a_pop_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ST_LOAD))
        else $error("queue popped outside load");

    a_no_emit_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !(w_blk_emit || w_end_emit))
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ===== sim/ess_record_checker.sv =====
// Checker for the envelope silence segmenter: watches both channels, predicts records, compares.
module ess_record_checker import ess_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [15:0]           i_sample,
    input  logic                  i_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_kind,
    input  logic [5:0]            i_block_index,
    input  logic [16:0]           i_start_sample,
    input  logic [16:0]           i_end_sample,
    input  logic [15:0]           i_max_amplitude,
    input  logic                  i_overflow,
    input  logic                  i_final_record,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int STORE_DEPTH = DEF_MAX_SAMPLES;
    localparam int BLOCK_LIMIT = DEF_MAX_BLOCKS;

    typedef struct {
        bit        kind;
        bit [5:0]  index;
        bit [16:0] first;
        bit [16:0] past;
        bit [15:0] amp;
        bit        ovf;
        bit        fin;
    } t_seg_record;

    t_seg_record expected_records[$];

    int unsigned magnitudes[STORE_DEPTH];
    int unsigned envelope[STORE_DEPTH];
    int unsigned stored_count;
    bit          dropped;

    bit [15:0] threshold;
    bit [24:0] min_silence;
    bit [24:0] min_block;
    bit [15:0] coeff;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        o_fail_count++;
    endtask

    function automatic int unsigned decay(input int unsigned peak);
        return int'((longint'(peak) * longint'(coeff)) >> 16);
    endfunction

    // Closes one region and queues a block record when it is loud and long enough.
    function automatic int close_region(input int k, input int unsigned s, input int unsigned e);
        int unsigned amp;
        t_seg_record rec;
        amp = 0;
        if (e <= s)
            return k;
        for (int unsigned j = s; j < e; j++)
            if (magnitudes[j] > amp)
                amp = magnitudes[j];
        if (amp < threshold || e - s < min_block)
            return k;
        if (k >= BLOCK_LIMIT) begin
            dropped = 1'b1;
            return k;
        end
        rec = '{KIND_BLOCK, 6'(k + 1), 17'(s), 17'(e), 16'(amp), 1'b0, 1'b0};
        expected_records = {expected_records, rec};
        return k + 1;
    endfunction

    task automatic predict_segments();
        int unsigned n, peak, d, sil_start, blk_start;
        bit in_sil, silent;
        int k;
        t_seg_record rec;
        n = stored_count;
        sil_start = 0;
        blk_start = 0;
        in_sil = 1'b0;
        k = 0;
        peak = 0;
        for (int unsigned i = 0; i < n; i++) begin
            d = decay(peak);
            peak = magnitudes[i] > d ? magnitudes[i] : d;
            envelope[i] = peak;
        end
        peak = 0;
        for (int unsigned i = n; i > 0; i--) begin
            d = decay(peak);
            peak = magnitudes[i-1] > d ? magnitudes[i-1] : d;
            if (peak > envelope[i-1])
                envelope[i-1] = peak;
        end
        for (int unsigned i = 0; i <= n; i++) begin
            silent = (i < n) && (envelope[i] < threshold);
            if (!in_sil && silent) begin
                sil_start = i;
                in_sil = 1'b1;
            end else if (in_sil && !silent) begin
                if (i - sil_start >= min_silence) begin
                    k = close_region(k, blk_start, sil_start);
                    blk_start = i;
                end
                in_sil = 1'b0;
            end
        end
        k = close_region(k, blk_start, n);
        rec = '{KIND_END, 6'(k), 17'd0, 17'd0, 16'd0, dropped, 1'b1};
        expected_records = {expected_records, rec};
        stored_count = 0;
        dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_seg_record want;
        if (!i_rst_n) begin
            threshold    = RST_THRESHOLD;
            min_silence  = RST_MIN_SIL;
            min_block    = RST_MIN_BLK;
            coeff        = RST_COEFF;
            stored_count = 0;
            dropped      = 1'b0;
            o_fail_count = 0;
            expected_records.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("record beyond expected, block_index", i_block_index, 0);
                end else begin
                    want = expected_records.pop_front();
                    if (i_kind != want.kind)
                        report_mismatch("kind", i_kind, want.kind);
                    if (i_block_index != want.index)
                        report_mismatch("block_index", i_block_index, want.index);
                    if (i_start_sample != want.first)
                        report_mismatch("start_sample", i_start_sample, want.first);
                    if (i_end_sample != want.past)
                        report_mismatch("end_sample", i_end_sample, want.past);
                    if (i_max_amplitude != want.amp)
                        report_mismatch("max_amplitude", i_max_amplitude, want.amp);
                    if (i_overflow != want.ovf)
                        report_mismatch("overflow", i_overflow, want.ovf);
                    if (i_final_record != want.fin)
                        report_mismatch("final_record", i_final_record, want.fin);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_THRESHOLD: threshold   = i_cfg_data[15:0];
                    CFG_MIN_SIL:   min_silence = i_cfg_data;
                    CFG_MIN_BLK:   min_block   = i_cfg_data;
                    CFG_COEFF:     coeff       = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (stored_count < STORE_DEPTH) begin
                    magnitudes[stored_count] = i_sample[15] ? 32'd65536 - i_sample : i_sample;
                    stored_count++;
                end else begin
                    dropped = 1'b1;
                end
                if (i_last)
                    predict_segments();
            end
        end
        o_pending = expected_records.size();
    end

endmodule

// ===== sim/tb_envelope_silence_segmenter_top.sv =====
// Testbench top: stimulus, handshake pressure and verdict for the envelope silence segmenter.
module tb_envelope_silence_segmenter_top;
    import ess_pkg::*;

    // Generous bound on the length of the whole run.
    localparam int CYCLE_LIMIT = 400_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [15:0]           i_sample = '0;
    logic                  i_last = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_kind;
    logic [5:0]            o_block_index;
    logic [16:0]           o_start_sample;
    logic [16:0]           o_end_sample;
    logic [15:0]           o_max_amplitude;
    logic                  o_overflow;
    logic                  o_final_record;

    int fail_count;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int beats_sent = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    envelope_silence_segmenter_top dut (.*);

    ess_record_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_sample(i_sample), .i_last(i_last),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_kind(o_kind),
        .i_block_index(o_block_index), .i_start_sample(o_start_sample),
        .i_end_sample(o_end_sample), .i_max_amplitude(o_max_amplitude),
        .i_overflow(o_overflow), .i_final_record(o_final_record),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake must not keep the run alive forever.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver stalls at random, or for a long fixed stretch when the stimulus
    // toggles hold_req. The stretch is counted here so that the sender keeps running.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // One input beat. Inputs move only at the falling edge; the beat is taken at the
    // first rising edge that sees o_stall low. Valid stays high into the next beat.
    task automatic send_beat(input logic [15:0] s, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        i_last   <= l;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    // Registers change only while the block is idle: every record has arrived and
    // the back end has had time to settle into the load state.
    task automatic set_regs(input int thr, input int sil, input int blk, input int cf);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data <= CFG_DATA_W'(thr);
        @(negedge i_clk);
        i_cfg_index <= CFG_MIN_SIL;
        i_cfg_data <= CFG_DATA_W'(sil);
        @(negedge i_clk);
        i_cfg_index <= CFG_MIN_BLK;
        i_cfg_data <= CFG_DATA_W'(blk);
        @(negedge i_clk);
        i_cfg_index <= CFG_COEFF;
        i_cfg_data <= CFG_DATA_W'(cf);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A recording of n samples: loud and quiet stretches around the threshold so that
    // silences and blocks form, or plain random words when noisy is set.
    task automatic send_recording(input int n, input bit noisy, input int thr);
        bit loud;
        int mag;
        logic [16:0] word;
        loud = $urandom_range(1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                loud = !loud;
            if (noisy)
                word = 17'($urandom);
            else begin
                mag = loud ? $urandom_range(32768, thr) : $urandom_range(thr / 2, 0);
                word = $urandom_range(1) ? 17'(0 - mag) : 17'(mag);
            end
            send_beat(word[15:0], i == n - 1);
        end
    endtask

    initial begin
        int thr;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, extreme samples; the one region is too short.
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'hFFFF, 1'b1);

        // No decay, one-sample silences: several blocks, two quiet regions.
        set_regs(100, 1, 1, 0);
        send_beat(16'd1000, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'd1000, 1'b0);
        send_beat(16'd5, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(-16'sd1000, 1'b1);

        // Highest threshold with full hold and zero minimum silence: only the first sample is loud.
        set_regs(32768, 0, 0, 65535);
        send_beat(16'h8000, 1'b0);
        send_beat(16'd5, 1'b0);
        send_beat(16'd7, 1'b1);

        // Zero threshold and minimums of 2^24: a recording of a single last beat.
        set_regs(0, 16777216, 16777216, 65535);
        send_beat(16'd123, 1'b1);
        set_regs(0, 0, 0, 1);
        send_beat(16'h5555, 1'b0);
        send_beat(16'hAAAA, 1'b1);

        // More loud stretches than record slots: excess blocks are dropped.
        set_regs(100, 1, 1, 0);
        for (int i = 0; i < 70; i++)
            send_beat(i[0] ? 16'd0 : 16'd500, i == 69);

        beats_sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 27 : 0;
            while (beats_sent < 120 * (phase + 1)) begin
                thr = $urandom_range(3) == 0 ? $urandom_range(32768) : $urandom_range(3000, 20);
                set_regs(thr, $urandom_range(6), $urandom_range(6),
                         $urandom_range(3) == 0 ? 0 : $urandom_range(65535, 40000));
                repeat ($urandom_range(3, 1))
                    send_recording($urandom_range(30, 1), $urandom_range(9) == 0, thr);
                if (phase == 0 && beats_sent < 60) begin
                    // Long result hold-off while the next recording is already offered.
                    hold_req = !hold_req;
                    send_recording(20, 1'b0, thr);
                end
            end
        end

        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
